### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define RSI_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("%m: check failed");
// Antecedent implies consequent in the same cycle.
`define RSI_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Antecedent implies consequent in the next cycle.
`define RSI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define RSI_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define RSI_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define RSI_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_W         = 24;
  localparam int ANG_W           = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int ROT_W           = 32;
  localparam int VEC_W           = 43;
  localparam int VEC_SHIFT       = 16;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = ROT_W + DIFF_W;
  localparam int SUM_W           = PROD_W + 1;
  localparam int DIV_W           = SUM_W + 1;
  localparam int QUO_W           = 32;
  localparam int S30_W           = 31;
  localparam int MX_W            = DIFF_W + S30_W + 1;
  localparam int PX_W            = COORD_W + 3;
  localparam int SQ_W            = 2 * PX_W;
  localparam int DSUM_W          = SQ_W + 1;
  localparam int DIST_W          = 49;
  localparam int FRAC_W          = 17;
  localparam int CFG_IDX_W       = 8;

  localparam logic [DSUM_W-1:0] MIN_DIST2 = DSUM_W'(
      ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd99999999) / 64'd100000000);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 32'sd652032875;
  localparam logic [ANG_W-1:0] ANG_HALF    = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANG_QUARTER = 32'h4000_0000;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER_S = 32'sh4000_0000;
  localparam logic signed [ANGLE_BITS-1:0] INC_LIMIT = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));

  localparam logic signed [MX_W-1:0] ROUND30 = MX_W'(1) <<< 29;
  localparam logic [S30_W:0] ROUND14 = (S30_W + 1)'(1) << 13;

  localparam logic signed [COORD_W-1:0] SEG_END_X_RST = COORD_W'(1 << COORD_FRAC_BITS);

  localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEG_START_X = 8'd0,
    REG_SEG_START_Y = 8'd1,
    REG_SEG_END_X   = 8'd2,
    REG_SEG_END_Y   = 8'd3
  } cfg_reg_t;

  // Geometry travelling alongside the CORDIC stages
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [DIFF_W-1:0]  vx;
    logic signed [DIFF_W-1:0]  vy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [ANG_W-1:0]          head;
  } rsi_geom_t;

  // Data needed after the divide
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [DIFF_W-1:0]  vx;
    logic signed [DIFF_W-1:0]  vy;
    logic [ANG_W-1:0]          head;
    logic [ANG_W-1:0]          seg_ang;
  } rsi_tail_t;

  function automatic logic [ANGLE_BITS-1:0] angle_out(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] t;
    t = a + (ANG_W'(1) << (ANG_W - 1 - ANGLE_BITS));
    return t[ANG_W-1 -: ANGLE_BITS];
  endfunction

endpackage

### rtl/rsi_ifs.sv
interface rsi_in_if;
  logic valid;
  logic ready;
  logic signed [rsi_pkg::COORD_W-1:0]    ray_origin_x;
  logic signed [rsi_pkg::COORD_W-1:0]    ray_origin_y;
  logic signed [rsi_pkg::ANGLE_BITS-1:0] ray_heading;
  modport source(output valid, ray_origin_x, ray_origin_y, ray_heading, input ready);
  modport sink(input valid, ray_origin_x, ray_origin_y, ray_heading, output ready);
endinterface

interface rsi_out_if;
  logic valid;
  logic ready;
  logic                                  hit;
  logic signed [rsi_pkg::COORD_W-1:0]    hit_x;
  logic signed [rsi_pkg::COORD_W-1:0]    hit_y;
  logic [rsi_pkg::FRAC_W-1:0]            seg_fraction;
  logic [rsi_pkg::DIST_W-1:0]            dist_squared;
  logic signed [rsi_pkg::ANGLE_BITS-1:0] incidence_angle;
  logic signed [rsi_pkg::ANGLE_BITS-1:0] normal_angle;
  logic                                  regular_side;
  modport source(output valid, hit, hit_x, hit_y, seg_fraction, dist_squared,
                 incidence_angle, normal_angle, regular_side, input ready);
  modport sink(input valid, hit, hit_x, hit_y, seg_fraction, dist_squared,
               incidence_angle, normal_angle, regular_side, output ready);
endinterface

interface rsi_cfg_if;
  logic valid;
  logic ready;
  logic [rsi_pkg::CFG_IDX_W-1:0] index;
  logic [rsi_pkg::COORD_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/rsi_cordic.sv
// Heading rotation (cos/sin) and segment vectoring (atan2) side by side,
// one micro-rotation per stage.
module rsi_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 vld_i,
  input  rsi_pkg::rsi_geom_t                   geom_i,
  output logic                                 vld_o,
  output rsi_pkg::rsi_geom_t                   geom_o,
  output logic signed [rsi_pkg::ROT_W-1:0]     cos_o,
  output logic signed [rsi_pkg::ROT_W-1:0]     sin_o,
  output logic                                 neg_o,
  output logic [rsi_pkg::ANG_W-1:0]            ang_o
);

  localparam int N = rsi_pkg::CORDIC_STEPS;

  logic signed [rsi_pkg::ANG_W-1:0] hz;
  logic signed [rsi_pkg::ANG_W-1:0] rz0;
  logic                             rneg0;
  logic signed [rsi_pkg::VEC_W-1:0] vx_raw, vy_raw, vx0, vy0;
  logic [rsi_pkg::ANG_W-1:0]        vz0;

  logic                             vld_r  [N];
  rsi_pkg::rsi_geom_t               geom_r [N];
  logic signed [rsi_pkg::ROT_W-1:0] rx_r   [N];
  logic signed [rsi_pkg::ROT_W-1:0] ry_r   [N];
  logic signed [rsi_pkg::ANG_W-1:0] rz_r   [N];
  logic                             rn_r   [N];
  logic signed [rsi_pkg::VEC_W-1:0] vx_r   [N];
  logic signed [rsi_pkg::VEC_W-1:0] vy_r   [N];
  logic [rsi_pkg::ANG_W-1:0]        vz_r   [N];

  // fold the heading into +-quarter turn; flipping the top bit is +-half turn
  always_comb begin
    hz    = $signed(geom_i.head);
    rz0   = hz;
    rneg0 = 1'b0;
    if (hz > rsi_pkg::ANG_QUARTER_S || hz < -rsi_pkg::ANG_QUARTER_S) begin
      rz0   = {~hz[rsi_pkg::ANG_W-1], hz[rsi_pkg::ANG_W-2:0]};
      rneg0 = 1'b1;
    end
  end

  always_comb begin
    vx_raw = rsi_pkg::VEC_W'(geom_i.vx) <<< rsi_pkg::VEC_SHIFT;
    vy_raw = rsi_pkg::VEC_W'(geom_i.vy) <<< rsi_pkg::VEC_SHIFT;
    if (vx_raw[rsi_pkg::VEC_W-1]) begin
      vx0 = -vx_raw;
      vy0 = -vy_raw;
      vz0 = rsi_pkg::ANG_HALF;
    end else begin
      vx0 = vx_raw;
      vy0 = vy_raw;
      vz0 = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                             vld_a;
    rsi_pkg::rsi_geom_t               geom_a;
    logic signed [rsi_pkg::ROT_W-1:0] rx_a, ry_a, rx_nxt, ry_nxt;
    logic signed [rsi_pkg::ANG_W-1:0] rz_a, rz_nxt;
    logic                             rn_a;
    logic signed [rsi_pkg::VEC_W-1:0] vx_a, vy_a, vx_nxt, vy_nxt;
    logic [rsi_pkg::ANG_W-1:0]        vz_a, vz_nxt;

    if (i == 0) begin : g_first
      assign vld_a  = vld_i;
      assign geom_a = geom_i;
      assign rx_a   = rsi_pkg::CORDIC_X0;
      assign ry_a   = '0;
      assign rz_a   = rz0;
      assign rn_a   = rneg0;
      assign vx_a   = vx0;
      assign vy_a   = vy0;
      assign vz_a   = vz0;
    end else begin : g_rest
      assign vld_a  = vld_r[i-1];
      assign geom_a = geom_r[i-1];
      assign rx_a   = rx_r[i-1];
      assign ry_a   = ry_r[i-1];
      assign rz_a   = rz_r[i-1];
      assign rn_a   = rn_r[i-1];
      assign vx_a   = vx_r[i-1];
      assign vy_a   = vy_r[i-1];
      assign vz_a   = vz_r[i-1];
    end

    always_comb begin
      if (!rz_a[rsi_pkg::ANG_W-1]) begin
        rx_nxt = rx_a - (ry_a >>> i);
        ry_nxt = ry_a + (rx_a >>> i);
        rz_nxt = rz_a - $signed(rsi_pkg::ATAN_TAB[i]);
      end else begin
        rx_nxt = rx_a + (ry_a >>> i);
        ry_nxt = ry_a - (rx_a >>> i);
        rz_nxt = rz_a + $signed(rsi_pkg::ATAN_TAB[i]);
      end
    end

    always_comb begin
      if (!vy_a[rsi_pkg::VEC_W-1]) begin
        vx_nxt = vx_a + (vy_a >>> i);
        vy_nxt = vy_a - (vx_a >>> i);
        vz_nxt = vz_a + rsi_pkg::ATAN_TAB[i];
      end else begin
        vx_nxt = vx_a - (vy_a >>> i);
        vy_nxt = vy_a + (vx_a >>> i);
        vz_nxt = vz_a - rsi_pkg::ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_a;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        geom_r[i] <= geom_a;
        rx_r[i]   <= rx_nxt;
        ry_r[i]   <= ry_nxt;
        rz_r[i]   <= rz_nxt;
        rn_r[i]   <= rn_a;
        vx_r[i]   <= vx_nxt;
        vy_r[i]   <= vy_nxt;
        vz_r[i]   <= vz_nxt;
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign geom_o = geom_r[N-1];
  assign cos_o  = rx_r[N-1];
  assign sin_o  = ry_r[N-1];
  assign neg_o  = rn_r[N-1];
  assign ang_o  = vz_r[N-1];

endmodule

### rtl/rsi_div.sv
// Restoring divider, one quotient bit per stage.
module rsi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         vld_i,
  input  logic                         miss_i,
  input  logic [rsi_pkg::DIV_W-1:0]    den_i,
  input  logic [rsi_pkg::DIV_W-1:0]    num_i,
  input  rsi_pkg::rsi_tail_t           tail_i,
  output logic                         vld_o,
  output logic                         miss_o,
  output logic [rsi_pkg::QUO_W-1:0]    quo_o,
  output rsi_pkg::rsi_tail_t           tail_o
);

  localparam int N = rsi_pkg::QUO_W;

  logic                        vld_r  [N];
  logic                        miss_r [N];
  logic [rsi_pkg::DIV_W-1:0]   den_r  [N];
  logic [rsi_pkg::DIV_W-1:0]   rem_r  [N];
  logic [rsi_pkg::QUO_W-1:0]   q_r    [N];
  rsi_pkg::rsi_tail_t          tail_r [N];

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic                        vld_a, miss_a, ge;
    logic [rsi_pkg::DIV_W-1:0]   den_a, rem_a, sh, rem_nxt;
    logic [rsi_pkg::QUO_W-1:0]   q_a, q_nxt;
    rsi_pkg::rsi_tail_t          tail_a;

    if (i == 0) begin : g_first
      assign vld_a  = vld_i;
      assign miss_a = miss_i;
      assign den_a  = den_i;
      assign rem_a  = num_i;
      assign q_a    = '0;
      assign tail_a = tail_i;
      assign sh     = rem_a;
    end else begin : g_rest
      assign vld_a  = vld_r[i-1];
      assign miss_a = miss_r[i-1];
      assign den_a  = den_r[i-1];
      assign rem_a  = rem_r[i-1];
      assign q_a    = q_r[i-1];
      assign tail_a = tail_r[i-1];
      assign sh     = {rem_a[rsi_pkg::DIV_W-2:0], 1'b0};
    end

    always_comb begin
      ge      = (sh >= den_a);
      rem_nxt = ge ? (sh - den_a) : sh;
      q_nxt   = {q_a[rsi_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_a;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        miss_r[i] <= miss_a;
        den_r[i]  <= den_a;
        rem_r[i]  <= rem_nxt;
        q_r[i]    <= q_nxt;
        tail_r[i] <= tail_a;
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign miss_o = miss_r[N-1];
  assign quo_o  = q_r[N-1];
  assign tail_o = tail_r[N-1];

endmodule

### rtl/ray_segment_intersect_top.sv
// Ray / segment intersection, 2D, fixed point. The segment endpoints A and B
// are set through the cfg port (index 0..3: start x, start y, end x, end y,
// signed Q8.16; reset gives A = (0,0), B = (1.0,0); other indices are
// ignored). Each request on the in channel carries a ray origin (Q8.16) and
// a heading (binary angle, half turn = 32768) and yields exactly one result
// request: hit flag, hit point, position along the segment measured from B
// (Q1.16), squared distance (Q17.32, saturating, all ones on a miss),
// incidence angle, the normal facing the ray and the side struck. Parallel
// rays, hits behind the origin, hits off the segment and hits closer than
// 0.0001 are misses with all fields but the distance zero. The datapath is
// one pipeline: a 30-stage CORDIC (heading cos/sin and segment atan2 in
// parallel), three stages of products and sign handling, a 32-stage
// one-bit-per-stage divider for the segment parameter, and five stages for
// hit point, distance and angles, plus input and output registers: 72
// register stages in all. A new request is taken every cycle; the whole
// pipeline holds when the output register is full and not being taken, so
// in ready follows out ready in the same cycle. Configuration must only
// change while the pipe is empty.
`include "assert_macros.svh"

module ray_segment_intersect_top (
  input  logic           clk,
  input  logic           rst_n,
  rsi_in_if.sink         in_chan,
  rsi_out_if.source      out_chan,
  rsi_cfg_if.sink        cfg_chan
);

  // segment registers
  logic signed [rsi_pkg::COORD_W-1:0] seg_sx_r, seg_sy_r, seg_ex_r, seg_ey_r;

  logic adv;

  // input stage
  logic               s0_vld_r;
  rsi_pkg::rsi_geom_t s0_geom_r, s0_geom_nxt;

  // CORDIC outputs
  logic                             c_vld, c_neg;
  rsi_pkg::rsi_geom_t               c_geom;
  logic signed [rsi_pkg::ROT_W-1:0] c_cos, c_sin;
  logic [rsi_pkg::ANG_W-1:0]        c_ang;

  // products
  logic                              m1_vld_r, m1_neg_r;
  logic signed [rsi_pkg::PROD_W-1:0] m1_p1_r, m1_p2_r, m1_p3_r, m1_p4_r, m1_p5_r, m1_p6_r;
  rsi_pkg::rsi_tail_t                m1_tail_r, m1_tail_nxt;

  // differences
  logic                             m2_vld_r;
  logic signed [rsi_pkg::SUM_W-1:0] m2_det_r, m2_sn_r, m2_tn_r;
  rsi_pkg::rsi_tail_t               m2_tail_r;

  // sign normalised
  logic                             m3_vld_r;
  logic signed [rsi_pkg::SUM_W-1:0] m3_dd_r, m3_rr_r, m3_tt_r;
  rsi_pkg::rsi_tail_t               m3_tail_r;
  logic                             m3_miss;

  // divider outputs
  logic                      d_vld, d_miss;
  logic [rsi_pkg::QUO_W-1:0] d_quo;
  rsi_pkg::rsi_tail_t        d_tail;
  logic [rsi_pkg::QUO_W:0]   d_qp1;

  // post-divide stages
  logic                       p1_vld_r, p1_miss_r;
  logic [rsi_pkg::S30_W-1:0]  p1_s30_r;
  rsi_pkg::rsi_tail_t         p1_tail_r;

  logic                            p2_vld_r, p2_miss_r;
  logic signed [rsi_pkg::MX_W-1:0] p2_mx_r, p2_my_r;
  logic [rsi_pkg::FRAC_W-1:0]      p2_frac_r;
  logic [rsi_pkg::S30_W:0]         p2_fsum;
  rsi_pkg::rsi_tail_t              p2_tail_r;

  logic                            p3_vld_r, p3_miss_r;
  logic signed [rsi_pkg::MX_W-1:0] p3_shx, p3_shy;
  logic signed [rsi_pkg::PX_W-1:0] p3_px_r, p3_py_r;
  logic [rsi_pkg::FRAC_W-1:0]      p3_frac_r;
  rsi_pkg::rsi_tail_t              p3_tail_r;

  logic                            p4_vld_r, p4_miss_r;
  logic signed [rsi_pkg::PX_W-1:0] p4_px_r, p4_py_r, p4_ex_r, p4_ey_r;
  logic [rsi_pkg::FRAC_W-1:0]      p4_frac_r;
  logic [rsi_pkg::ANG_W-1:0]       p4_inc_r, p4_seg_r;

  logic                            p5_vld_r, p5_miss_r;
  logic signed [rsi_pkg::PX_W-1:0] p5_px_r, p5_py_r;
  logic signed [rsi_pkg::SQ_W-1:0] p5_sqx_prod, p5_sqy_prod;
  logic [rsi_pkg::SQ_W-1:0]        p5_sqx_r, p5_sqy_r;
  logic [rsi_pkg::FRAC_W-1:0]      p5_frac_r;
  logic [rsi_pkg::ANG_W-1:0]       p5_inc_r, p5_seg_r;

  // final combine
  logic [rsi_pkg::DSUM_W-1:0]          f_dist;
  logic                                f_hit, f_side;
  logic signed [rsi_pkg::ANG_W-1:0]    f_incs;

  // output register
  logic                                  out_vld_r;
  logic                                  out_hit_r, out_side_r;
  logic signed [rsi_pkg::COORD_W-1:0]    out_hit_x_r, out_hit_y_r;
  logic [rsi_pkg::FRAC_W-1:0]            out_frac_r;
  logic [rsi_pkg::DIST_W-1:0]            out_dist_r;
  logic signed [rsi_pkg::ANGLE_BITS-1:0] out_inc_r, out_norm_r;
  logic                                  out_hit_nxt, out_side_nxt;
  logic signed [rsi_pkg::COORD_W-1:0]    out_hit_x_nxt, out_hit_y_nxt;
  logic [rsi_pkg::FRAC_W-1:0]            out_frac_nxt;
  logic [rsi_pkg::DIST_W-1:0]            out_dist_nxt;
  logic signed [rsi_pkg::ANGLE_BITS-1:0] out_inc_nxt, out_norm_nxt;

  // ---------------------------------------------------------------------
  // Configuration: always ready, unknown indices dropped
  // ---------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_sx_r <= '0;
      seg_sy_r <= '0;
      seg_ex_r <= rsi_pkg::SEG_END_X_RST;
      seg_ey_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (rsi_pkg::cfg_reg_t'(cfg_chan.index))
        rsi_pkg::REG_SEG_START_X: seg_sx_r <= $signed(cfg_chan.data);
        rsi_pkg::REG_SEG_START_Y: seg_sy_r <= $signed(cfg_chan.data);
        rsi_pkg::REG_SEG_END_X:   seg_ex_r <= $signed(cfg_chan.data);
        rsi_pkg::REG_SEG_END_Y:   seg_ey_r <= $signed(cfg_chan.data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: every stage moves when the output slot frees up
  // ---------------------------------------------------------------------
  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Input stage: v = A - B, d = O - B
  always_comb begin
    s0_geom_nxt.ox   = in_chan.ray_origin_x;
    s0_geom_nxt.oy   = in_chan.ray_origin_y;
    s0_geom_nxt.bx   = seg_ex_r;
    s0_geom_nxt.by   = seg_ey_r;
    s0_geom_nxt.vx   = rsi_pkg::DIFF_W'(seg_sx_r) - rsi_pkg::DIFF_W'(seg_ex_r);
    s0_geom_nxt.vy   = rsi_pkg::DIFF_W'(seg_sy_r) - rsi_pkg::DIFF_W'(seg_ey_r);
    s0_geom_nxt.dx   = rsi_pkg::DIFF_W'(in_chan.ray_origin_x) - rsi_pkg::DIFF_W'(seg_ex_r);
    s0_geom_nxt.dy   = rsi_pkg::DIFF_W'(in_chan.ray_origin_y) - rsi_pkg::DIFF_W'(seg_ey_r);
    s0_geom_nxt.head = {in_chan.ray_heading, {(rsi_pkg::ANG_W - rsi_pkg::ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_geom_r <= s0_geom_nxt;
    end
  end

  rsi_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (s0_vld_r),
    .geom_i (s0_geom_r),
    .vld_o  (c_vld),
    .geom_o (c_geom),
    .cos_o  (c_cos),
    .sin_o  (c_sin),
    .neg_o  (c_neg),
    .ang_o  (c_ang)
  );

  // ---------------------------------------------------------------------
  // Cramer's rule. The folded-heading negation flips det and s_num only,
  // so it is applied by swapping the subtraction operands.
  // ---------------------------------------------------------------------
  always_comb begin
    m1_tail_nxt.ox      = c_geom.ox;
    m1_tail_nxt.oy      = c_geom.oy;
    m1_tail_nxt.bx      = c_geom.bx;
    m1_tail_nxt.by      = c_geom.by;
    m1_tail_nxt.vx      = c_geom.vx;
    m1_tail_nxt.vy      = c_geom.vy;
    m1_tail_nxt.head    = c_geom.head;
    m1_tail_nxt.seg_ang = c_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= c_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p1_r   <= rsi_pkg::PROD_W'(c_cos) * rsi_pkg::PROD_W'(c_geom.vy);
      m1_p2_r   <= rsi_pkg::PROD_W'(c_geom.vx) * rsi_pkg::PROD_W'(c_sin);
      m1_p3_r   <= rsi_pkg::PROD_W'(c_cos) * rsi_pkg::PROD_W'(c_geom.dy);
      m1_p4_r   <= rsi_pkg::PROD_W'(c_sin) * rsi_pkg::PROD_W'(c_geom.dx);
      m1_p5_r   <= rsi_pkg::PROD_W'(c_geom.vx) * rsi_pkg::PROD_W'(c_geom.dy);
      m1_p6_r   <= rsi_pkg::PROD_W'(c_geom.vy) * rsi_pkg::PROD_W'(c_geom.dx);
      m1_neg_r  <= c_neg;
      m1_tail_r <= m1_tail_nxt;

      m2_det_r  <= m1_neg_r ? (rsi_pkg::SUM_W'(m1_p2_r) - rsi_pkg::SUM_W'(m1_p1_r))
                            : (rsi_pkg::SUM_W'(m1_p1_r) - rsi_pkg::SUM_W'(m1_p2_r));
      m2_sn_r   <= m1_neg_r ? (rsi_pkg::SUM_W'(m1_p4_r) - rsi_pkg::SUM_W'(m1_p3_r))
                            : (rsi_pkg::SUM_W'(m1_p3_r) - rsi_pkg::SUM_W'(m1_p4_r));
      m2_tn_r   <= rsi_pkg::SUM_W'(m1_p5_r) - rsi_pkg::SUM_W'(m1_p6_r);
      m2_tail_r <= m1_tail_r;

      // make det positive
      if (m2_det_r[rsi_pkg::SUM_W-1]) begin
        m3_dd_r <= -m2_det_r;
        m3_rr_r <= -m2_sn_r;
        m3_tt_r <= -m2_tn_r;
      end else begin
        m3_dd_r <= m2_det_r;
        m3_rr_r <= m2_sn_r;
        m3_tt_r <= m2_tn_r;
      end
      m3_tail_r <= m2_tail_r;
    end
  end

  // parallel ray, s outside [0,1] or hit behind the origin
  assign m3_miss = (m3_dd_r == '0) || m3_rr_r[rsi_pkg::SUM_W-1] ||
                   (m3_rr_r > m3_dd_r) || m3_tt_r[rsi_pkg::SUM_W-1];

  rsi_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (m3_vld_r),
    .miss_i (m3_miss),
    .den_i  (rsi_pkg::DIV_W'($unsigned(m3_dd_r))),
    .num_i  (rsi_pkg::DIV_W'($unsigned(m3_rr_r))),
    .tail_i (m3_tail_r),
    .vld_o  (d_vld),
    .miss_o (d_miss),
    .quo_o  (d_quo),
    .tail_o (d_tail)
  );

  // ---------------------------------------------------------------------
  // Hit point, distance, angles
  // ---------------------------------------------------------------------
  assign d_qp1   = {1'b0, d_quo} + (rsi_pkg::QUO_W + 1)'(1);
  assign p2_fsum = {1'b0, p1_s30_r} + rsi_pkg::ROUND14;
  assign p3_shx  = (p2_mx_r + rsi_pkg::ROUND30) >>> 30;
  assign p3_shy  = (p2_my_r + rsi_pkg::ROUND30) >>> 30;
  assign p5_sqx_prod = rsi_pkg::SQ_W'(p4_ex_r) * rsi_pkg::SQ_W'(p4_ex_r);
  assign p5_sqy_prod = rsi_pkg::SQ_W'(p4_ey_r) * rsi_pkg::SQ_W'(p4_ey_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= d_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // s30 = round(q / 2)
      p1_s30_r  <= d_qp1[rsi_pkg::S30_W:1];
      p1_miss_r <= d_miss;
      p1_tail_r <= d_tail;

      p2_mx_r   <= rsi_pkg::MX_W'(p1_tail_r.vx) * rsi_pkg::MX_W'($signed({1'b0, p1_s30_r}));
      p2_my_r   <= rsi_pkg::MX_W'(p1_tail_r.vy) * rsi_pkg::MX_W'($signed({1'b0, p1_s30_r}));
      p2_frac_r <= p2_fsum[rsi_pkg::S30_W-1:14];
      p2_miss_r <= p1_miss_r;
      p2_tail_r <= p1_tail_r;

      p3_px_r   <= rsi_pkg::PX_W'(p2_tail_r.bx) + $signed(p3_shx[rsi_pkg::PX_W-1:0]);
      p3_py_r   <= rsi_pkg::PX_W'(p2_tail_r.by) + $signed(p3_shy[rsi_pkg::PX_W-1:0]);
      p3_frac_r <= p2_frac_r;
      p3_miss_r <= p2_miss_r;
      p3_tail_r <= p2_tail_r;

      p4_px_r   <= p3_px_r;
      p4_py_r   <= p3_py_r;
      p4_ex_r   <= p3_px_r - rsi_pkg::PX_W'(p3_tail_r.ox);
      p4_ey_r   <= p3_py_r - rsi_pkg::PX_W'(p3_tail_r.oy);
      p4_inc_r  <= p3_tail_r.head - p3_tail_r.seg_ang + rsi_pkg::ANG_QUARTER;
      p4_seg_r  <= p3_tail_r.seg_ang;
      p4_frac_r <= p3_frac_r;
      p4_miss_r <= p3_miss_r;

      p5_sqx_r  <= $unsigned(p5_sqx_prod);
      p5_sqy_r  <= $unsigned(p5_sqy_prod);
      p5_px_r   <= p4_px_r;
      p5_py_r   <= p4_py_r;
      p5_inc_r  <= p4_inc_r;
      p5_seg_r  <= p4_seg_r;
      p5_frac_r <= p4_frac_r;
      p5_miss_r <= p4_miss_r;
    end
  end

  // final combine into the output register
  always_comb begin
    f_dist = {1'b0, p5_sqx_r} + {1'b0, p5_sqy_r};
    f_hit  = !p5_miss_r && (f_dist >= rsi_pkg::MIN_DIST2);
    f_incs = $signed(p5_inc_r);
    // grazing incidence falls on the far side
    f_side = (f_incs > -rsi_pkg::ANG_QUARTER_S) && (f_incs < rsi_pkg::ANG_QUARTER_S);

    out_hit_nxt   = 1'b0;
    out_hit_x_nxt = '0;
    out_hit_y_nxt = '0;
    out_frac_nxt  = '0;
    out_dist_nxt  = rsi_pkg::DIST_MAX;
    out_inc_nxt   = '0;
    out_norm_nxt  = '0;
    out_side_nxt  = 1'b0;
    if (f_hit) begin
      out_hit_nxt   = 1'b1;
      out_hit_x_nxt = p5_px_r[rsi_pkg::COORD_W-1:0];
      out_hit_y_nxt = p5_py_r[rsi_pkg::COORD_W-1:0];
      out_frac_nxt  = p5_frac_r;
      if (f_dist > rsi_pkg::DSUM_W'(rsi_pkg::DIST_MAX)) begin
        out_dist_nxt = rsi_pkg::DIST_MAX;
      end else begin
        out_dist_nxt = f_dist[rsi_pkg::DIST_W-1:0];
      end
      if (f_side) begin
        out_inc_nxt  = $signed(rsi_pkg::angle_out(p5_inc_r));
        out_norm_nxt = $signed(rsi_pkg::angle_out(p5_seg_r + rsi_pkg::ANG_QUARTER));
        out_side_nxt = 1'b1;
      end else begin
        out_inc_nxt  = $signed(rsi_pkg::angle_out(p5_inc_r - rsi_pkg::ANG_HALF));
        out_norm_nxt = $signed(rsi_pkg::angle_out(p5_seg_r - rsi_pkg::ANG_QUARTER));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r   <= out_hit_nxt;
      out_hit_x_r <= out_hit_x_nxt;
      out_hit_y_r <= out_hit_y_nxt;
      out_frac_r  <= out_frac_nxt;
      out_dist_r  <= out_dist_nxt;
      out_inc_r   <= out_inc_nxt;
      out_norm_r  <= out_norm_nxt;
      out_side_r  <= out_side_nxt;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.hit             = out_hit_r;
  assign out_chan.hit_x           = out_hit_x_r;
  assign out_chan.hit_y           = out_hit_y_r;
  assign out_chan.seg_fraction    = out_frac_r;
  assign out_chan.dist_squared    = out_dist_r;
  assign out_chan.incidence_angle = out_inc_r;
  assign out_chan.normal_angle    = out_norm_r;
  assign out_chan.regular_side    = out_side_r;

  // a hit never reports a distance under the minimum
  `RSI_ASSERT_IMPL(a_hit_min_dist, clk, rst_n, out_vld_r && out_hit_r, rsi_pkg::DSUM_W'(out_dist_r) >= rsi_pkg::MIN_DIST2)
  // a miss carries the fixed miss pattern
  `RSI_ASSERT_IMPL(a_miss_fields, clk, rst_n, out_vld_r && !out_hit_r, (out_dist_r == rsi_pkg::DIST_MAX) && (out_hit_x_r == '0) && (out_side_r == 1'b0))
  // front-side incidence stays within a quarter turn
  `RSI_ASSERT_IMPL(a_inc_range, clk, rst_n, out_vld_r && out_side_r, (out_inc_r >= -rsi_pkg::INC_LIMIT) && (out_inc_r <= rsi_pkg::INC_LIMIT))
  // a stall holds the input stage
  `RSI_ASSERT_NEXT(a_stall_hold, clk, rst_n, s0_vld_r && !adv, s0_vld_r)

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rsi_pkg::CFG_IDX_W-1:0] BAD_REG_IDX = 8'hA5;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PIPE_LATENCY = 72;
  localparam int RANDOM_PHASES = 6;
  localparam int RAYS_PER_PHASE = 310;

  // one intersection result as seen on the out channel
  typedef struct {
    logic                                  hit;
    logic signed [rsi_pkg::COORD_W-1:0]    hit_x;
    logic signed [rsi_pkg::COORD_W-1:0]    hit_y;
    logic [rsi_pkg::FRAC_W-1:0]            seg_fraction;
    logic [rsi_pkg::DIST_W-1:0]            dist_squared;
    logic signed [rsi_pkg::ANGLE_BITS-1:0] incidence_angle;
    logic signed [rsi_pkg::ANGLE_BITS-1:0] normal_angle;
    logic                                  regular_side;
  } hit_rec_t;

  // Keeps its own copy of the segment and predicts each hit record.
  class hit_tracker;
    longint seg_reg[4];
    hit_rec_t pending_hits[$];
    int errors;

    function new();
      seg_reg[0] = 0;
      seg_reg[1] = 0;
      seg_reg[2] = longint'(1) << rsi_pkg::COORD_FRAC_BITS;
      seg_reg[3] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [rsi_pkg::CFG_IDX_W-1:0] idx,
                            logic [rsi_pkg::COORD_W-1:0] val);
      if (idx < 4) seg_reg[idx] = longint'($signed(val));
    endfunction

    function logic [rsi_pkg::ANGLE_BITS-1:0] round_ang(logic [31:0] a);
      logic [31:0] t;
      t = a + (32'd1 << (31 - rsi_pkg::ANGLE_BITS));
      return t[31 -: rsi_pkg::ANGLE_BITS];
    endfunction

    function void note_ray(logic signed [rsi_pkg::COORD_W-1:0] rx,
                           logic signed [rsi_pkg::COORD_W-1:0] ry,
                           logic [rsi_pkg::ANGLE_BITS-1:0] hd);
      hit_rec_t e;
      logic [31:0] head, seg_ang, inc;
      longint ox, oy, ax, ay, bx, by, x, y, z, nx, ny, ux, uy;
      longint vx, vy, dx, dy, det, snum, tnum, px, py, ex, ey, s30, incs;
      logic [63:0] dd, r, q, dsq;
      bit flip;
      e = '{hit: 0, hit_x: 0, hit_y: 0, seg_fraction: 0, dist_squared: rsi_pkg::DIST_MAX,
            incidence_angle: 0, normal_angle: 0, regular_side: 0};
      ox = rx; oy = ry;
      ax = seg_reg[0]; ay = seg_reg[1]; bx = seg_reg[2]; by = seg_reg[3];
      head = {hd, {(32 - rsi_pkg::ANGLE_BITS){1'b0}}};
      // heading cos/sin, rotation mode folded into +-quarter turn
      z = longint'($signed(head));
      flip = 0;
      if (z > (longint'(1) << 30)) begin
        z -= longint'(1) << 31; flip = 1;
      end else if (z < -(longint'(1) << 30)) begin
        z += longint'(1) << 31; flip = 1;
      end
      x = 652032875; y = 0;
      for (int i = 0; i < rsi_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(rsi_pkg::ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(rsi_pkg::ATAN_TAB[i]);
        end
        x = nx; y = ny;
      end
      ux = flip ? -x : x;
      uy = flip ? -y : y;
      vx = ax - bx; vy = ay - by;
      dx = ox - bx; dy = oy - by;
      det = ux * vy - vx * uy;
      snum = ux * dy - uy * dx;
      tnum = vx * dy - vy * dx;
      if (det < 0) begin
        det = -det; snum = -snum; tnum = -tnum;
      end
      if (det != 0 && snum >= 0 && snum <= det && tnum >= 0) begin
        dd = det; r = snum;
        q = (r >= dd) ? 64'd1 : 64'd0;
        if (q != 0) r -= dd;
        for (int k = 0; k < 31; k++) begin
          r = r << 1; q = q << 1;
          if (r >= dd) begin
            r -= dd; q |= 64'd1;
          end
        end
        s30 = longint'((q + 64'd1) >> 1);
        px = bx + ((vx * s30 + (longint'(1) << 29)) >>> 30);
        py = by + ((vy * s30 + (longint'(1) << 29)) >>> 30);
        ex = px - ox; ey = py - oy;
        dsq = ex * ex + ey * ey;
        if (dsq >= 64'(rsi_pkg::MIN_DIST2)) begin
          if (dsq > 64'(rsi_pkg::DIST_MAX)) dsq = 64'(rsi_pkg::DIST_MAX);
          // segment direction, vectoring mode
          x = vx * 65536; y = vy * 65536; seg_ang = 0;
          if (x < 0) begin
            x = -x; y = -y; seg_ang = 32'h8000_0000;
          end
          for (int i = 0; i < rsi_pkg::CORDIC_STEPS; i++) begin
            if (y >= 0) begin
              nx = x + (y >>> i); ny = y - (x >>> i); seg_ang += rsi_pkg::ATAN_TAB[i];
            end else begin
              nx = x - (y >>> i); ny = y + (x >>> i); seg_ang -= rsi_pkg::ATAN_TAB[i];
            end
            x = nx; y = ny;
          end
          inc = head - seg_ang + 32'h4000_0000;
          incs = longint'($signed(inc));
          e.hit = 1;
          e.hit_x = px[rsi_pkg::COORD_W-1:0];
          e.hit_y = py[rsi_pkg::COORD_W-1:0];
          e.seg_fraction = rsi_pkg::FRAC_W'((s30 + (longint'(1) << 13)) >>> 14);
          e.dist_squared = dsq[rsi_pkg::DIST_W-1:0];
          if (incs > -(longint'(1) << 30) && incs < (longint'(1) << 30)) begin
            e.incidence_angle = round_ang(inc);
            e.normal_angle = round_ang(seg_ang + 32'h4000_0000);
            e.regular_side = 1;
          end else begin
            e.incidence_angle = round_ang(inc - 32'h8000_0000);
            e.normal_angle = round_ang(seg_ang - 32'h4000_0000);
          end
        end
      end
      pending_hits = {pending_hits, e};
    endfunction

    function void check_hit(hit_rec_t got);
      hit_rec_t e;
      if (pending_hits.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
      end
      if (got.hit_x !== e.hit_x) begin
        $error("hit_x: expected %0d, got %0d", e.hit_x, got.hit_x); errors++;
      end
      if (got.hit_y !== e.hit_y) begin
        $error("hit_y: expected %0d, got %0d", e.hit_y, got.hit_y); errors++;
      end
      if (got.seg_fraction !== e.seg_fraction) begin
        $error("seg_fraction: expected %0d, got %0d", e.seg_fraction, got.seg_fraction);
        errors++;
      end
      if (got.dist_squared !== e.dist_squared) begin
        $error("dist_squared: expected %0d, got %0d", e.dist_squared, got.dist_squared);
        errors++;
      end
      if (got.incidence_angle !== e.incidence_angle) begin
        $error("incidence_angle: expected %0d, got %0d", e.incidence_angle,
               got.incidence_angle);
        errors++;
      end
      if (got.normal_angle !== e.normal_angle) begin
        $error("normal_angle: expected %0d, got %0d", e.normal_angle, got.normal_angle);
        errors++;
      end
      if (got.regular_side !== e.regular_side) begin
        $error("regular_side: expected %0d, got %0d", e.regular_side, got.regular_side);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;   // final stretch: both sides flat out
  int   cycles;
  int   stall_left;
  int   gap_left;
  longint seg_ax, seg_ay, seg_bx, seg_by;  // segment as last written, for aiming rays
  hit_tracker tracker;
  hit_rec_t got;

  rsi_in_if  in_bus();
  rsi_out_if out_bus();
  rsi_cfg_if cfg_bus();

  ray_segment_intersect_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // sink side: random back-pressure bursts unless in the final stretch
  always @(negedge clk) begin
    if (!rst_n || no_idle) begin
      out_bus.ready = rst_n;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_bus.ready = 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n && out_bus.valid && out_bus.ready) begin
      got.hit = out_bus.hit;
      got.hit_x = out_bus.hit_x;
      got.hit_y = out_bus.hit_y;
      got.seg_fraction = out_bus.seg_fraction;
      got.dist_squared = out_bus.dist_squared;
      got.incidence_angle = out_bus.incidence_angle;
      got.normal_angle = out_bus.normal_angle;
      got.regular_side = out_bus.regular_side;
      tracker.check_hit(got);
    end
  end

  // one config write; only called with the pipe drained
  task automatic write_seg(logic [rsi_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsi_pkg::COORD_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = val;
    do @(posedge clk); while (!cfg_bus.ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_segment(longint ax, longint ay, longint bx, longint by);
    write_seg(rsi_pkg::REG_SEG_START_X, ax[rsi_pkg::COORD_W-1:0]);
    write_seg(rsi_pkg::REG_SEG_START_Y, ay[rsi_pkg::COORD_W-1:0]);
    write_seg(rsi_pkg::REG_SEG_END_X, bx[rsi_pkg::COORD_W-1:0]);
    write_seg(rsi_pkg::REG_SEG_END_Y, by[rsi_pkg::COORD_W-1:0]);
    // stray index must be ignored
    write_seg(BAD_REG_IDX, rsi_pkg::COORD_W'($urandom));
    seg_ax = ax; seg_ay = ay; seg_bx = bx; seg_by = by;
  endtask

  // one ray request; valid stays high into the next call unless a gap is drawn
  task automatic send_ray(longint ox, longint oy, longint hd);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      gap_left = $urandom_range(1, 7);
      repeat (gap_left - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.ray_origin_x = ox[rsi_pkg::COORD_W-1:0];
    in_bus.ray_origin_y = oy[rsi_pkg::COORD_W-1:0];
    in_bus.ray_heading = hd[rsi_pkg::ANGLE_BITS-1:0];
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_ray(in_bus.ray_origin_x, in_bus.ray_origin_y, in_bus.ray_heading);
  endtask

  task automatic drain;
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.pending_hits.size() != 0) @(posedge clk);
  endtask

  function automatic longint clamp_coord(real v);
    if (v > 8388607.0) return 8388607;
    if (v < -8388608.0) return -8388608;
    return longint'(v);
  endfunction

  // Mostly rays aimed at a random point on the segment (those reach the
  // divider and angle stages), some with a nudged heading, the rest noise.
  task automatic random_ray(int reach);
    real s, tx, ty, ox, oy, ang;
    longint hd;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      s = $urandom_range(0, 65536) / 65536.0;
      tx = seg_bx + s * (seg_ax - seg_bx);
      ty = seg_by + s * (seg_ay - seg_by);
      ox = tx + $signed($urandom_range(0, 2 * reach)) - reach;
      oy = ty + $signed($urandom_range(0, 2 * reach)) - reach;
      ox = clamp_coord(ox);
      oy = clamp_coord(oy);
      ang = $atan2(ty - oy, tx - ox) * 32768.0 / 3.14159265358979;
      hd = longint'(ang);
      if (pick == 6) hd += $signed($urandom_range(0, 64)) - 32;
      send_ray(longint'(ox), longint'(oy), hd);
    end else if (pick < 9) begin
      send_ray(seg_bx + $signed($urandom_range(0, 2 * reach)) - reach,
               seg_by + $signed($urandom_range(0, 2 * reach)) - reach, $urandom);
    end else begin
      send_ray($signed(rsi_pkg::COORD_W'($urandom)), $signed(rsi_pkg::COORD_W'($urandom)),
               $urandom);
    end
  endtask

  function automatic longint rand_coord(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    longint one;
    int reach;
    one = longint'(1) << rsi_pkg::COORD_FRAC_BITS;
    tracker = new();
    cycles = 0;
    stall_left = 0;
    no_idle = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.ray_origin_x = '0;
    in_bus.ray_origin_y = '0;
    in_bus.ray_heading = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    seg_ax = 0; seg_ay = 0; seg_bx = one; seg_by = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset segment (0,0)-(1,0): plain hits from either side, both endpoints,
    // a ray pointing away, off the end, parallel, and origin on the segment.
    send_ray(one / 2, -one, 16384);
    send_ray(one / 2, one, -16384);
    send_ray(0, -one, 16384);
    send_ray(one, -one, 16384);
    send_ray(one / 2, -one, -16384);
    send_ray(2 * one, -one, 16384);
    send_ray(-one, 0, 0);
    send_ray(2 * one, 0, -32768);
    send_ray(one / 2, 0, 16384);
    send_ray(one / 4, -one, 8192);
    send_ray(-8388608, 8388607, 32767);
    send_ray(8388607, -8388608, -32768);
    drain;

    // degenerate segment: start equals end
    set_segment(3 * one, -2 * one, 3 * one, -2 * one);
    send_ray(0, 0, 0);
    send_ray(3 * one, -3 * one, 16384);
    drain;

    // extreme endpoints: vertical at the left edge, rays from far corners
    set_segment(-8388608, 8388607, -8388608, -8388608);
    send_ray(8388607, 8388607, -24576);
    send_ray(8388607, -8388608, 24576);
    send_ray(8388607, 0, -32768);
    send_ray(8388607, 0, 32767);
    send_ray(-8388607, 0, -32768);
    drain;

    // random segments, small ones first (a full-range diagonal in phase 1), then full range, final one flat out
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      reach = (p < 3) ? (4 * one) : 8388607;
      if (p == 1)
        set_segment(8388607, 8388607, -8388608, -8388608);
      else
        set_segment(rand_coord(reach), rand_coord(reach), rand_coord(reach),
                    rand_coord(reach));
      if (p == RANDOM_PHASES - 1) no_idle = 1;
      for (int n = 0; n < RAYS_PER_PHASE; n++) random_ray(reach > 4 * one ? 2 * one : reach);
      drain;
    end

    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
